// ===== design/dnd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dnd_pkg;

  // Walk address width: a 14-bit pointer target plus one label of up to 0xBF bytes.
  localparam int POS_W   = 15;
  localparam int OFF_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int CHUNK_W = 64;
  localparam int CNT_W   = 4;
  localparam int ST_W    = 2;
  localparam int HOP_W   = 6;
  localparam int CHARS_W = 8;

  localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;
  localparam logic [1:0]        PTR_TAG  = 2'b11;
  localparam logic [CNT_W-1:0]  CHUNK_FULL = 4'd8;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_HOPS  = 2'd1,
    ST_RANGE = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  // Command to the chunk packer.
  typedef struct packed {
    logic              clear;
    logic              append;
    logic [BYTE_W-1:0] ch;
  } chunk_cmd_t;

  // Result of the shared address incrementer and bound compare.
  typedef struct packed {
    logic [POS_W-1:0] inc;
    logic             beyond;
  } addr_res_t;

endpackage

`default_nettype wire

// ===== design/dnd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/dnd_addr_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnd_addr_unit #(
  parameter int MSG_BYTES = 512
) (
  input  wire logic [dnd_pkg::POS_W-1:0] pos,
  input  wire logic [dnd_pkg::POS_W-1:0] cur,
  input  wire logic                      sel_pos,
  output dnd_pkg::addr_res_t             res
);

  import dnd_pkg::*;

  localparam logic [POS_W-1:0] LIMIT = POS_W'(MSG_BYTES);

  logic [POS_W-1:0] operand;

  // One incrementer and one bound compare, shared by every walk step.
  always_comb begin
    operand    = sel_pos ? pos : cur;
    res.inc    = operand + POS_W'(1);
    res.beyond = (operand >= LIMIT);
  end

endmodule

`default_nettype wire

// ===== design/dnd_chunk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnd_chunk (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dnd_pkg::chunk_cmd_t         cmd,
  output logic      [dnd_pkg::CHUNK_W-1:0] chunk,
  output logic      [dnd_pkg::CNT_W-1:0]   fill
);

  import dnd_pkg::*;

  logic [CHUNK_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;

  always_comb begin
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    if (cmd.clear) begin
      buf_nxt  = '0;
      fill_nxt = '0;
    end else if (cmd.append) begin
      buf_nxt[{fill_r[2:0], 3'b000} +: BYTE_W] = cmd.ch;
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign chunk = buf_r;
  assign fill  = fill_r;

endmodule

`default_nettype wire

// ===== design/dns_name_decompressor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake               Payload
// in_       in   in_tvalid / in_tready   tdata: offset[8:0], byte_in[16:9]; tuser: func
// out_      out  out_tvalid / out_tready tdata: text_chunk[63:0], chunk_count[67:64],
//                                        status[69:68]; tlast: final_chunk
// cfg_      in   cfg_valid / cfg_ready   cfg_data: hop_limit
//
// A load item is written to the message RAM when accepted, if its address lies in
// the store. A decode item is accepted, then walks the name through the single read
// port of the message RAM (registered read), reading each length byte (the closing
// zero included), each pointer and each label character, and putting a dot between
// labels; each full chunk and the final chunk is sent. in_tready is low for the whole walk.
// Reset is synchronous, active low; it clears control state and sets hop_limit to 16.
// A stalled out_ channel holds the walk only when a chunk must be sent and the
// output register is still occupied; a waiting result never blocks a new item.

module dns_name_decompressor #(
  parameter int MSG_BYTES      = 512,
  parameter int MAX_NAME_CHARS = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // offset[8:0], byte_in[16:9], zero pad
  input  wire logic        in_tuser,   // func
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [71:0] out_tdata,  // text_chunk[63:0], chunk_count[67:64],
                                       // status[69:68], zero pad
  output logic             out_tlast,  // final_chunk
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data    // hop_limit
);

  import dnd_pkg::*;

  localparam int AW = $clog2(MSG_BYTES);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LEN_RD   = 8'b0000_0010,
    S_LEN_WAIT = 8'b0000_0100,
    S_PTR_WAIT = 8'b0000_1000,
    S_CHR_RD   = 8'b0001_0000,
    S_CHR_WAIT = 8'b0010_0000,
    S_PUT      = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   cur_r, cur_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0]  ch_r, ch_nxt;
  logic               dot_r, dot_nxt;
  logic [CHARS_W-1:0] chars_r, chars_nxt;
  logic [HOP_W-1:0]   hops_r, hops_nxt;
  logic [HOP_W-1:0]   hop_limit_r;
  status_t            st_r, st_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CHUNK_W-1:0] out_text_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_last_r;
  status_t            out_st_r;

  logic               in_acc;
  logic               slot_free;
  logic               load_out, load_final;

  logic [OFF_W-1:0]   in_offset;
  logic [BYTE_W-1:0]  in_byte;
  logic [POS_W-1:0]   off_ext;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  addr_res_t          au;
  chunk_cmd_t         ccmd;
  logic [CHUNK_W-1:0] chunk;
  logic [CNT_W-1:0]   fill;

  assign in_offset = in_tdata[OFF_W-1:0];
  assign in_byte   = in_tdata[OFF_W +: BYTE_W];
  assign off_ext   = POS_W'(in_offset);

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Store loads; an address beyond the store is dropped.
  assign ram_we = in_acc && !in_tuser && (off_ext < POS_W'(MSG_BYTES));

  dnd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MSG_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (off_ext[AW-1:0]),
    .wdata (in_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dnd_addr_unit #(
    .MSG_BYTES (MSG_BYTES)
  ) u_addr (
    .pos     (pos_r),
    .cur     (cur_r),
    .sel_pos (state_r == S_LEN_RD),
    .res     (au)
  );

  dnd_chunk u_chunk (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ccmd),
    .chunk (chunk),
    .fill  (fill)
  );

  // Walk sequencer.
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    ch_nxt     = ch_r;
    dot_nxt    = dot_r;
    chars_nxt  = chars_r;
    hops_nxt   = hops_r;
    st_nxt     = st_r;
    ram_re     = 1'b0;
    ram_raddr  = cur_r[AW-1:0];
    ccmd       = '{clear: 1'b0, append: 1'b0, ch: ch_r};
    load_out   = 1'b0;
    load_final = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser) begin
          pos_nxt    = off_ext;
          chars_nxt  = '0;
          hops_nxt   = '0;
          ccmd.clear = 1'b1;
          state_nxt  = S_LEN_RD;
        end
      end
      S_LEN_RD: begin
        ram_raddr = pos_r[AW-1:0];
        if (au.beyond) begin
          st_nxt    = ST_RANGE;
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          cur_nxt   = au.inc;
          state_nxt = S_LEN_WAIT;
        end
      end
      S_LEN_WAIT: begin
        len_nxt = ram_rdata;
        if (ram_rdata == '0) begin
          st_nxt    = ST_OK;
          state_nxt = S_FIN;
        end else if (ram_rdata[7:6] == PTR_TAG) begin
          // Pointer: its low byte sits right after the tag byte.
          if (au.beyond) begin
            st_nxt    = ST_RANGE;
            state_nxt = S_FIN;
          end else if (hops_r >= hop_limit_r) begin
            st_nxt    = ST_HOPS;
            state_nxt = S_FIN;
          end else begin
            ram_re    = 1'b1;
            state_nxt = S_PTR_WAIT;
          end
        end else begin
          rem_nxt = ram_rdata;
          if (chars_r != '0) begin
            ch_nxt    = DOT_CHAR;
            dot_nxt   = 1'b1;
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_CHR_RD;
          end
        end
      end
      S_PTR_WAIT: begin
        pos_nxt   = POS_W'({len_r[5:0], ram_rdata});
        hops_nxt  = hops_r + HOP_W'(1);
        state_nxt = S_LEN_RD;
      end
      S_CHR_RD: begin
        if (au.beyond) begin
          st_nxt    = ST_RANGE;
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_CHR_WAIT;
        end
      end
      S_CHR_WAIT: begin
        ch_nxt    = ram_rdata;
        dot_nxt   = 1'b0;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (chars_r >= CHARS_W'(MAX_NAME_CHARS)) begin
          st_nxt    = ST_LONG;
          state_nxt = S_FIN;
        end else if (fill == CHUNK_FULL) begin
          // Send the full chunk first; hold while the output is occupied.
          if (slot_free) begin
            load_out   = 1'b1;
            ccmd.clear = 1'b1;
          end
        end else begin
          ccmd.append = 1'b1;
          chars_nxt   = chars_r + CHARS_W'(1);
          if (dot_r) begin
            state_nxt = S_CHR_RD;
          end else if (rem_r == BYTE_W'(1)) begin
            pos_nxt   = au.inc;
            state_nxt = S_LEN_RD;
          end else begin
            rem_nxt   = rem_r - BYTE_W'(1);
            cur_nxt   = au.inc;
            state_nxt = S_CHR_RD;
          end
        end
      end
      S_FIN: begin
        if (slot_free) begin
          load_out   = 1'b1;
          load_final = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cur_r  <= cur_nxt;
    len_r  <= len_nxt;
    rem_r  <= rem_nxt;
    ch_r   <= ch_nxt;
    dot_r  <= dot_nxt;
    st_r   <= st_nxt;
    if (load_out) begin
      out_text_r <= chunk;
      out_cnt_r  <= fill;
      out_last_r <= load_final;
      out_st_r   <= load_final ? st_r : ST_OK;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chars_r     <= '0;
      hops_r      <= '0;
      hop_limit_r <= HOP_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chars_r     <= chars_nxt;
      hops_r      <= hops_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        hop_limit_r <= cfg_data;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_st_r, out_cnt_r, out_text_r};

  // The chunk never holds more than eight characters.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= CHUNK_FULL)
    else $error("chunk fill above eight");

  // Pointer hops stay within the limit for the whole walk.
  a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (hops_r <= hop_limit_r))
    else $error("hop count above limit");

  // The name never grows past its limit.
  a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chars_r <= CHARS_W'(MAX_NAME_CHARS))
    else $error("name length above limit");

  // A chunk sent mid-name is never the last one and always carries eight characters.
  a_mid_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !load_final) |=> (out_cnt_r == CHUNK_FULL && !out_last_r))
    else $error("partial chunk sent before end of name");

endmodule

`default_nettype wire
